// File: rtl/f32rs_pkg.sv
// ----------------------------------------------------------------------------
// f32rs_pkg
// Shared types, codes and constants of the FAT32 root short-name finder.
// ----------------------------------------------------------------------------
package f32rs_pkg;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_WAIT  = 8'b0000_0010,
    S_PARSE = 8'b0000_0100,
    S_CHK1  = 8'b0000_1000,
    S_CHK2  = 8'b0001_0000,
    S_CHK3  = 8'b0010_0000,
    S_CLUS1 = 8'b0100_0000,
    S_CLUS2 = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    PH_BOOT = 2'd0,
    PH_DIR  = 2'd1,
    PH_FAT  = 2'd2
  } phase_t;

  localparam logic       REQ_START = 1'b0;
  localparam logic       KIND_READ = 1'b0;
  localparam logic       KIND_DONE = 1'b1;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_BAD_BOOT = 3'd1;
  localparam logic [2:0] ST_END_DIR  = 3'd2;
  localparam logic [2:0] ST_OUTSIDE  = 3'd3;
  localparam logic [2:0] ST_CHAIN    = 3'd4;
  localparam logic [2:0] ST_BAD_CLUS = 3'd5;

  localparam logic [1:0] CFG_NAME_HEAD  = 2'd0;
  localparam logic [1:0] CFG_NAME_TAIL  = 2'd1;
  localparam logic [1:0] CFG_IMAGE_SIZE = 2'd2;

  localparam int         BOOT_SECTOR_BYTES = 512;
  localparam int         BOOT_CAPTURE_DEPTH = 48;
  localparam logic [5:0] BOOT_LAST   = 6'd47;
  localparam logic [4:0] BOOT_FIELDS = 5'd18;

  localparam logic [7:0]  MARK_END  = 8'h00;
  localparam logic [7:0]  MARK_DEL  = 8'hE5;
  localparam logic [7:0]  ATTR_LFN  = 8'h0F;
  localparam int          ATTR_VOL_BIT = 3;
  localparam logic [27:0] FAT_EOC   = 28'hFFFFFF8;

  localparam logic [5:0] ENT_NAME_LAST = 6'd10;
  localparam logic [5:0] ENT_ATTR      = 6'd11;
  localparam logic [5:0] ENT_HI0       = 6'd20;
  localparam logic [5:0] ENT_HI1       = 6'd21;
  localparam logic [5:0] ENT_LO0       = 6'd26;
  localparam logic [5:0] ENT_LO1       = 6'd27;
  localparam logic [5:0] ENT_SZ0       = 6'd28;
  localparam logic [5:0] ENT_SZ1       = 6'd29;
  localparam logic [5:0] ENT_SZ2       = 6'd30;
  localparam logic [5:0] ENT_LAST      = 6'd31;

  // Boot sector bytes that the checks need, in the order they are read back
  function automatic logic [5:0] boot_field_addr(input logic [4:0] idx);
    logic [5:0] a;
    case (idx)
      5'd0:    a = 6'd11;
      5'd1:    a = 6'd12;
      5'd2:    a = 6'd13;
      5'd3:    a = 6'd14;
      5'd4:    a = 6'd15;
      5'd5:    a = 6'd16;
      5'd6:    a = 6'd17;
      5'd7:    a = 6'd18;
      5'd8:    a = 6'd22;
      5'd9:    a = 6'd23;
      5'd10:   a = 6'd36;
      5'd11:   a = 6'd37;
      5'd12:   a = 6'd38;
      5'd13:   a = 6'd39;
      5'd14:   a = 6'd44;
      5'd15:   a = 6'd45;
      5'd16:   a = 6'd46;
      5'd17:   a = 6'd47;
      default: a = 6'd0;
    endcase
    return a;
  endfunction

  function automatic logic [3:0] log2_16(input logic [15:0] v);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) r = 4'(i);
    end
    return r;
  endfunction

endpackage

// File: rtl/f32rs_if.sv
// ----------------------------------------------------------------------------
// f32rs_if
// Request and result channels of the FAT32 root short-name finder.
// ----------------------------------------------------------------------------
interface f32rs_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] read_byte;
  modport source(output valid, req_type, read_byte, input ready);
  modport sink(input valid, req_type, read_byte, output ready);
endinterface

interface f32rs_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [31:0] read_address;
  logic [2:0]  status;
  logic [31:0] first_cluster;
  logic [31:0] file_size;
  logic [31:0] data_offset;
  logic [22:0] cluster_bytes;
  modport source(output valid, out_kind, read_address, status, first_cluster, file_size,
                 data_offset, cluster_bytes, input ready);
  modport sink(input valid, out_kind, read_address, status, first_cluster, file_size,
               data_offset, cluster_bytes, output ready);
endinterface

// File: rtl/f32rs_ram.sv
// ----------------------------------------------------------------------------
// f32rs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module f32rs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/fat32_root_short_name_finder.sv
// ----------------------------------------------------------------------------
// fat32_root_short_name_finder
// Looks up an 11-character short name in the root directory of a FAT32 image.
// ----------------------------------------------------------------------------
// A start request opens a lookup; the block answers each request of a running
// lookup with one result: either a read request for one image byte or a
// finish with status. Each returned byte is taken and the next read request
// is registered from it, so a fast memory can return one byte per cycle while
// the sink keeps ready high. After the 48th boot sector byte the captured
// bytes are read back from the boot capture RAM one a cycle and checked;
// each cluster of the root chain passes S_CLUS1 and S_CLUS2 for its base
// address. A new request is taken while the sink takes the previous result.
module fat32_root_short_name_finder (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  f32rs_in_if.sink      in_ch,
  f32rs_out_if.source   out_ch
);

  // configuration
  logic [63:0] name_head;
  logic [23:0] name_tail;
  logic [31:0] image_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      name_head  <= '0;
      name_tail  <= '0;
      image_size <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        f32rs_pkg::CFG_NAME_HEAD:  name_head  <= cfg_data;
        f32rs_pkg::CFG_NAME_TAIL:  name_tail  <= cfg_data[23:0];
        f32rs_pkg::CFG_IMAGE_SIZE: image_size <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // control and walk state
  f32rs_pkg::state_t state, state_next;
  f32rs_pkg::phase_t phase, phase_next;
  logic [5:0]   bi, bi_next;
  logic [4:0]   pcnt, pcnt_next;
  logic [143:0] fld;
  logic [3:0]   lgb, lgb_next;
  logic [2:0]   lgs, lgs_next;
  logic [4:0]   lgc, lgc_next;
  logic [63:0]  fo_r, fo_r_next;
  logic [39:0]  nffs, nffs_next;
  logic [63:0]  fat_off, fat_off_next;
  logic [63:0]  dof, dof_next;
  logic [22:0]  csize, csize_next;
  logic [31:0]  cc, cc_next;
  logic [31:0]  hop, hop_next;
  logic [32:0]  hop_limit, hop_limit_next;
  logic [63:0]  base_r, base_r_next;
  logic [63:0]  fat_addr, fat_addr_next;
  logic [63:0]  entry_addr, entry_addr_next;
  logic [63:0]  rd_addr, rd_addr_next;
  logic [16:0]  eidx, eidx_next;
  logic [31:0]  fat_word, fat_word_next;
  logic         match, match_next;
  logic [31:0]  ent_fc, ent_fc_next;
  logic [23:0]  ent_fs, ent_fs_next;

  // result register
  logic        out_valid;
  logic        out_kind;
  logic [31:0] out_addr;
  logic [2:0]  out_status;
  logic [31:0] out_fc;
  logic [31:0] out_fs;

  logic in_fire;
  logic [7:0] b;
  logic [7:0] rdata;
  logic ram_we;
  logic [5:0] ram_raddr;

  assign in_ch.ready = ((state == f32rs_pkg::S_IDLE) || (state == f32rs_pkg::S_WAIT))
                       && (!out_valid || out_ch.ready);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign b       = in_ch.read_byte;
  assign ram_we  = in_fire && (in_ch.req_type != f32rs_pkg::REQ_START)
                   && (state == f32rs_pkg::S_WAIT) && (phase == f32rs_pkg::PH_BOOT);
  assign ram_raddr = f32rs_pkg::boot_field_addr(pcnt);

  f32rs_ram #(.WIDTH(8), .DEPTH(f32rs_pkg::BOOT_CAPTURE_DEPTH)) u_boot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bi),
    .wdata (b),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // boot sector fields, byte k of the read-back list at fld[8k +: 8]
  logic [15:0] f_bps, f_rsv, f_17, f_22;
  logic [7:0]  f_spc, f_nf;
  logic [31:0] f_fs32, f_root;
  assign f_bps  = fld[15:0];
  assign f_spc  = fld[23:16];
  assign f_rsv  = fld[39:24];
  assign f_nf   = fld[47:40];
  assign f_17   = fld[63:48];
  assign f_22   = fld[79:64];
  assign f_fs32 = fld[111:80];
  assign f_root = fld[143:112];

  logic        emit_rd, emit_fin;
  logic [2:0]  fin_st;
  logic [31:0] fin_fc, fin_fs;
  logic        go_next_entry, go_fat;
  logic [7:0]  want;
  logic [31:0] fword;
  logic [27:0] fnext;
  logic [63:0] dof_c;
  logic        boot_bad;

  always_comb begin
    if (bi < 6'd8) want = name_head[{bi[2:0], 3'b000} +: 8];
    else           want = name_tail[{bi[1:0], 3'b000} +: 8];
  end

  assign fword = fat_word | ({24'b0, b} << {bi[1:0], 3'b000});
  assign fnext = fword[27:0];
  assign dof_c = fo_r + ({24'b0, nffs} << lgb);
  assign boot_bad = (f_bps == 16'd0) || ((f_bps & (f_bps - 16'd1)) != 16'd0)
                    || (f_spc == 8'd0) || ((f_spc & (f_spc - 8'd1)) != 8'd0)
                    || (f_nf == 8'd0) || (f_17 != 16'd0) || (f_22 != 16'd0)
                    || (f_fs32 == 32'd0) || (f_root < 32'd2);

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    bi_next         = bi;
    pcnt_next       = pcnt;
    lgb_next        = lgb;
    lgs_next        = lgs;
    lgc_next        = lgc;
    fo_r_next       = fo_r;
    nffs_next       = nffs;
    fat_off_next    = fat_off;
    dof_next        = dof;
    csize_next      = csize;
    cc_next         = cc;
    hop_next        = hop;
    hop_limit_next  = hop_limit;
    base_r_next     = base_r;
    fat_addr_next   = fat_addr;
    entry_addr_next = entry_addr;
    rd_addr_next    = rd_addr;
    eidx_next       = eidx;
    fat_word_next   = fat_word;
    match_next      = match;
    ent_fc_next     = ent_fc;
    ent_fs_next     = ent_fs;
    emit_rd         = 1'b0;
    emit_fin        = 1'b0;
    fin_st          = f32rs_pkg::ST_FOUND;
    fin_fc          = '0;
    fin_fs          = '0;
    go_next_entry   = 1'b0;
    go_fat          = 1'b0;

    unique case (state)
      f32rs_pkg::S_IDLE, f32rs_pkg::S_WAIT: begin
        if (in_fire && in_ch.req_type == f32rs_pkg::REQ_START) begin
          fat_off_next  = '0;
          dof_next      = '0;
          csize_next    = '0;
          cc_next       = '0;
          eidx_next     = '0;
          bi_next       = '0;
          fat_word_next = '0;
          hop_next      = '0;
          if (image_size < 32'(f32rs_pkg::BOOT_SECTOR_BYTES)) begin
            emit_fin = 1'b1;
            fin_st   = f32rs_pkg::ST_BAD_BOOT;
          end else begin
            phase_next   = f32rs_pkg::PH_BOOT;
            rd_addr_next = '0;
            emit_rd      = 1'b1;
          end
        end else if (in_fire && state == f32rs_pkg::S_WAIT) begin
          case (phase)
            f32rs_pkg::PH_BOOT: begin
              if (bi == f32rs_pkg::BOOT_LAST) begin
                pcnt_next  = '0;
                state_next = f32rs_pkg::S_PARSE;
              end else begin
                bi_next      = bi + 6'd1;
                rd_addr_next = {58'b0, bi + 6'd1};
                emit_rd      = 1'b1;
              end
            end
            f32rs_pkg::PH_DIR: begin
              if (bi == 6'd0) match_next = (b == want);
              else if (bi <= f32rs_pkg::ENT_NAME_LAST) match_next = match && (b == want);
              case (bi)
                f32rs_pkg::ENT_HI0: ent_fc_next[23:16] = b;
                f32rs_pkg::ENT_HI1: ent_fc_next[31:24] = b;
                f32rs_pkg::ENT_LO0: ent_fc_next[7:0]   = b;
                f32rs_pkg::ENT_LO1: ent_fc_next[15:8]  = b;
                f32rs_pkg::ENT_SZ0: ent_fs_next[7:0]   = b;
                f32rs_pkg::ENT_SZ1: ent_fs_next[15:8]  = b;
                f32rs_pkg::ENT_SZ2: ent_fs_next[23:16] = b;
                default: ;
              endcase
              if (bi == 6'd0 && b == f32rs_pkg::MARK_END) begin
                emit_fin = 1'b1;
                fin_st   = f32rs_pkg::ST_END_DIR;
              end else if (bi == 6'd0 && b == f32rs_pkg::MARK_DEL) begin
                go_next_entry = 1'b1;
              end else if (bi == f32rs_pkg::ENT_ATTR && (b == f32rs_pkg::ATTR_LFN
                           || b[f32rs_pkg::ATTR_VOL_BIT] || !match)) begin
                go_next_entry = 1'b1;
              end else if (bi >= f32rs_pkg::ENT_LAST) begin
                emit_fin = 1'b1;
                if (ent_fc < 32'd2) begin
                  fin_st = f32rs_pkg::ST_BAD_CLUS;
                end else begin
                  fin_st = f32rs_pkg::ST_FOUND;
                  fin_fc = ent_fc;
                  fin_fs = {b, ent_fs};
                end
              end else begin
                bi_next      = bi + 6'd1;
                rd_addr_next = rd_addr + 64'd1;
                emit_rd      = 1'b1;
              end
            end
            f32rs_pkg::PH_FAT: begin
              if (bi < 6'd3) begin
                fat_word_next = fword;
                bi_next       = bi + 6'd1;
                rd_addr_next  = rd_addr + 64'd1;
                emit_rd       = 1'b1;
              end else if (fnext >= f32rs_pkg::FAT_EOC || fnext == 28'd0) begin
                emit_fin = 1'b1;
                fin_st   = f32rs_pkg::ST_CHAIN;
              end else if ({1'b0, hop} + 33'd1 >= hop_limit) begin
                emit_fin = 1'b1;
                fin_st   = f32rs_pkg::ST_CHAIN;
              end else begin
                hop_next   = hop + 32'd1;
                cc_next    = {4'b0, fnext};
                state_next = f32rs_pkg::S_CLUS1;
              end
            end
            default: ;
          endcase
        end
      end
      f32rs_pkg::S_PARSE: begin
        // read back one field byte a cycle; the RAM registers its read data
        if (pcnt == f32rs_pkg::BOOT_FIELDS) state_next = f32rs_pkg::S_CHK1;
        else pcnt_next = pcnt + 5'd1;
      end
      f32rs_pkg::S_CHK1: begin
        if (boot_bad) begin
          emit_fin = 1'b1;
          fin_st   = f32rs_pkg::ST_BAD_BOOT;
        end else begin
          lgb_next   = f32rs_pkg::log2_16(f_bps);
          lgs_next   = 3'(f32rs_pkg::log2_16({8'b0, f_spc}));
          state_next = f32rs_pkg::S_CHK2;
        end
      end
      f32rs_pkg::S_CHK2: begin
        // sizes are powers of two: the byte-per-sector products are shifts
        fo_r_next  = {48'b0, f_rsv} << lgb;
        nffs_next  = 40'(f_nf) * 40'(f_fs32);
        lgc_next   = {1'b0, lgb} + {2'b0, lgs};
        state_next = f32rs_pkg::S_CHK3;
      end
      f32rs_pkg::S_CHK3: begin
        if (fo_r >= {32'b0, image_size} || dof_c >= {32'b0, image_size}) begin
          emit_fin = 1'b1;
          fin_st   = f32rs_pkg::ST_BAD_BOOT;
        end else begin
          fat_off_next   = fo_r;
          dof_next       = dof_c;
          csize_next     = 23'd1 << lgc;
          cc_next        = f_root;
          hop_next       = '0;
          hop_limit_next = {1'b0, image_size >> lgc} + 33'd2;
          state_next     = f32rs_pkg::S_CLUS1;
        end
      end
      f32rs_pkg::S_CLUS1: begin
        base_r_next   = dof + ({32'b0, cc - 32'd2} << lgc);
        fat_addr_next = fat_off + {30'b0, cc, 2'b00};
        if (cc < 32'd2) begin
          emit_fin = 1'b1;
          fin_st   = f32rs_pkg::ST_CHAIN;
        end else begin
          state_next = f32rs_pkg::S_CLUS2;
        end
      end
      f32rs_pkg::S_CLUS2: begin
        if (base_r + {41'b0, csize} > {32'b0, image_size}) begin
          emit_fin = 1'b1;
          fin_st   = f32rs_pkg::ST_OUTSIDE;
        end else begin
          eidx_next = '0;
          bi_next   = '0;
          if (csize < 23'd32) begin
            go_fat = 1'b1;
          end else begin
            phase_next      = f32rs_pkg::PH_DIR;
            entry_addr_next = base_r;
            rd_addr_next    = base_r;
            emit_rd         = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (go_next_entry) begin
      if ({1'b0, eidx} + 18'd1 >= csize[22:5]) begin
        go_fat = 1'b1;
      end else begin
        eidx_next       = eidx + 17'd1;
        bi_next         = '0;
        entry_addr_next = entry_addr + 64'd32;
        rd_addr_next    = entry_addr + 64'd32;
        emit_rd         = 1'b1;
      end
    end

    if (go_fat) begin
      if (fat_addr + 64'd4 > {32'b0, image_size}) begin
        emit_fin = 1'b1;
        fin_st   = f32rs_pkg::ST_OUTSIDE;
      end else begin
        phase_next    = f32rs_pkg::PH_FAT;
        bi_next       = '0;
        fat_word_next = '0;
        rd_addr_next  = fat_addr;
        emit_rd       = 1'b1;
      end
    end

    if (emit_fin) state_next = f32rs_pkg::S_IDLE;
    else if (emit_rd) state_next = f32rs_pkg::S_WAIT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= f32rs_pkg::S_IDLE;
      phase      <= f32rs_pkg::PH_BOOT;
      out_valid  <= 1'b0;
      bi         <= '0;
      pcnt       <= '0;
      fat_off    <= '0;
      dof        <= '0;
      csize      <= '0;
      cc         <= '0;
      hop        <= '0;
      eidx       <= '0;
      fat_word   <= '0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      bi       <= bi_next;
      pcnt     <= pcnt_next;
      fat_off  <= fat_off_next;
      dof      <= dof_next;
      csize    <= csize_next;
      cc       <= cc_next;
      hop      <= hop_next;
      eidx     <= eidx_next;
      fat_word <= fat_word_next;
      if (emit_rd || emit_fin) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    lgb        <= lgb_next;
    lgs        <= lgs_next;
    lgc        <= lgc_next;
    fo_r       <= fo_r_next;
    nffs       <= nffs_next;
    hop_limit  <= hop_limit_next;
    base_r     <= base_r_next;
    fat_addr   <= fat_addr_next;
    entry_addr <= entry_addr_next;
    rd_addr    <= rd_addr_next;
    match      <= match_next;
    ent_fc     <= ent_fc_next;
    ent_fs     <= ent_fs_next;
    if (state == f32rs_pkg::S_PARSE && pcnt != 5'd0) fld <= {rdata, fld[143:8]};
    if (emit_rd || emit_fin) begin
      out_kind   <= emit_fin ? f32rs_pkg::KIND_DONE : f32rs_pkg::KIND_READ;
      out_addr   <= emit_fin ? 32'd0 : rd_addr_next[31:0];
      out_status <= emit_fin ? fin_st : f32rs_pkg::ST_FOUND;
      out_fc     <= fin_fc;
      out_fs     <= fin_fs;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.out_kind      = out_kind;
  assign out_ch.read_address  = out_addr;
  assign out_ch.status        = out_status;
  assign out_ch.first_cluster = out_fc;
  assign out_ch.file_size     = out_fs;
  assign out_ch.data_offset   = dof[31:0];
  assign out_ch.cluster_bytes = csize;

  a_start_reads_zero: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_ch.req_type == f32rs_pkg::REQ_START && image_size >= 32'd512
    |=> out_valid && out_kind == f32rs_pkg::KIND_READ && out_addr == 32'd0)
    else $error("start did not request byte zero");

  a_done_is_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == f32rs_pkg::KIND_DONE |-> state == f32rs_pkg::S_IDLE)
    else $error("finish reported while a lookup still runs");

  a_dir_cluster_size: assert property (@(posedge clk) disable iff (rst)
    state == f32rs_pkg::S_WAIT && phase == f32rs_pkg::PH_DIR |-> csize >= 23'd32)
    else $error("directory scan in a cluster smaller than one entry");

  a_dir_address: assert property (@(posedge clk) disable iff (rst)
    state == f32rs_pkg::S_WAIT && phase == f32rs_pkg::PH_DIR
    |-> rd_addr == entry_addr + {58'b0, bi})
    else $error("directory read address out of step with entry");

endmodule

// File: test/fat32_root_short_name_finder_tb.sv
// ----------------------------------------------------------------------------
// fat32_root_short_name_finder_tb
// Drives lookups against generated FAT32 images: a short table of edge cases,
// then random volumes whose bytes mostly answer each predicted read request.
// Results are checked against a cycle-free predictor or typed table entries.
// ----------------------------------------------------------------------------
module fat32_root_short_name_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic       REQ_BYTE = ~f32rs_pkg::REQ_START;
  localparam logic [2:0] ST_NONE  = f32rs_pkg::ST_FOUND;
  localparam int         WD_LIMIT = 5000;
  localparam int         ITEM_GOAL = 900;

  typedef enum logic [1:0] {LK_IDLE, LK_BOOT, LK_DIR, LK_FAT} lk_phase_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] addr;
    logic [2:0]  status;
    logic [31:0] fc;
    logic [31:0] fsz;
    logic [31:0] doff;
    logic [22:0] cb;
  } lookup_res_t;

  typedef struct {
    bit          set_img;
    logic [31:0] img;
    logic        rt;
    logic [7:0]  b;
    int          reps;
    bit          typed;
    logic        kind;
    logic [31:0] addr;
    logic [2:0]  st;
  } seed_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  f32rs_in_if  in_ch();
  f32rs_out_if out_ch();

  fat32_root_short_name_finder u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // predictor state
  logic [63:0] cfg_head;
  logic [23:0] cfg_tail;
  logic [31:0] cfg_img;
  lk_phase_t   ph;
  logic [7:0]  boot_cap [48];
  logic [7:0]  entbuf [32];
  logic [63:0] fat_off, data_off;
  logic [31:0] csz, cur_cl, ent_idx, fword, hops;
  logic [7:0]  bidx;

  lookup_res_t pending_res[$];
  logic [7:0]  img_mem [logic [31:0]];
  logic [31:0] next_addr;
  int          errors = 0;
  int          n_items = 0;
  int          burst_left = 0;
  int          rdy_left = 0;
  int          wd = 0;

  function automatic lookup_res_t mk_res(logic k, logic [63:0] a, logic [2:0] st,
                                         logic [31:0] fc, logic [31:0] fs);
    lookup_res_t r;
    r.kind = k; r.addr = a[31:0]; r.status = st; r.fc = fc; r.fsz = fs;
    r.doff = data_off[31:0]; r.cb = csz[22:0];
    return r;
  endfunction

  function automatic lookup_res_t finish_with(logic [2:0] st, logic [31:0] fc,
                                              logic [31:0] fs);
    ph = LK_IDLE;
    return mk_res(f32rs_pkg::KIND_DONE, 64'd0, st, fc, fs);
  endfunction

  function automatic logic [63:0] clus_base();
    return data_off + 64'(cur_cl - 32'd2) * 64'(csz);
  endfunction

  function automatic lookup_res_t entry_read();
    return mk_res(f32rs_pkg::KIND_READ, clus_base() + 64'(ent_idx) * 64'd32 + 64'(bidx),
                  ST_NONE, 0, 0);
  endfunction

  function automatic lookup_res_t fat_read_start();
    logic [63:0] eoff;
    eoff = fat_off + 64'(cur_cl) * 64'd4;
    if (eoff + 64'd4 > 64'(cfg_img)) return finish_with(f32rs_pkg::ST_OUTSIDE, 0, 0);
    ph = LK_FAT;
    bidx = 0;
    fword = 0;
    return mk_res(f32rs_pkg::KIND_READ, eoff, ST_NONE, 0, 0);
  endfunction

  function automatic lookup_res_t cluster_enter();
    if (cur_cl < 32'd2) return finish_with(f32rs_pkg::ST_CHAIN, 0, 0);
    if (clus_base() + 64'(csz) > 64'(cfg_img)) return finish_with(f32rs_pkg::ST_OUTSIDE, 0, 0);
    ent_idx = 0;
    bidx = 0;
    if (csz / 32 == 0) return fat_read_start();
    ph = LK_DIR;
    return entry_read();
  endfunction

  function automatic lookup_res_t entry_advance();
    if (ent_idx + 32'd1 >= csz / 32) return fat_read_start();
    ent_idx++;
    bidx = 0;
    return entry_read();
  endfunction

  function automatic lookup_res_t boot_check();
    logic [31:0] bps, spc, rsv, nf, fs32, root;
    logic [63:0] fo, dof;
    bps  = 32'({boot_cap[12], boot_cap[11]});
    spc  = 32'(boot_cap[13]);
    rsv  = 32'({boot_cap[15], boot_cap[14]});
    nf   = 32'(boot_cap[16]);
    fs32 = {boot_cap[39], boot_cap[38], boot_cap[37], boot_cap[36]};
    root = {boot_cap[47], boot_cap[46], boot_cap[45], boot_cap[44]};
    if (bps == 0 || (bps & (bps - 1)) != 0) return finish_with(f32rs_pkg::ST_BAD_BOOT, 0, 0);
    if (spc == 0 || (spc & (spc - 1)) != 0) return finish_with(f32rs_pkg::ST_BAD_BOOT, 0, 0);
    if (nf == 0 || {boot_cap[18], boot_cap[17]} != 0 || {boot_cap[23], boot_cap[22]} != 0 ||
        fs32 == 0 || root < 2)
      return finish_with(f32rs_pkg::ST_BAD_BOOT, 0, 0);
    fo  = 64'(rsv) * 64'(bps);
    dof = fo + 64'(nf) * 64'(fs32) * 64'(bps);
    if (fo >= 64'(cfg_img) || dof >= 64'(cfg_img))
      return finish_with(f32rs_pkg::ST_BAD_BOOT, 0, 0);
    fat_off = fo;
    data_off = dof;
    csz = bps * spc;
    cur_cl = root;
    hops = 0;
    return cluster_enter();
  endfunction

  function automatic bit name_hit();
    logic [7:0] want;
    for (int i = 0; i < 11; i++) begin
      want = (i < 8) ? cfg_head[8*i +: 8] : cfg_tail[8*(i-8) +: 8];
      if (entbuf[i] != want) return 0;
    end
    return 1;
  endfunction

  function automatic lookup_res_t dir_take(logic [7:0] b);
    logic [31:0] fc;
    entbuf[bidx[4:0]] = b;
    if (bidx == 0) begin
      if (b == f32rs_pkg::MARK_END) return finish_with(f32rs_pkg::ST_END_DIR, 0, 0);
      if (b == f32rs_pkg::MARK_DEL) return entry_advance();
    end else if (bidx == 8'(f32rs_pkg::ENT_ATTR)) begin
      if (b == f32rs_pkg::ATTR_LFN || b[f32rs_pkg::ATTR_VOL_BIT] || !name_hit())
        return entry_advance();
    end else if (bidx >= 8'(f32rs_pkg::ENT_LAST)) begin
      fc = {entbuf[21], entbuf[20], entbuf[27], entbuf[26]};
      if (fc < 2) return finish_with(f32rs_pkg::ST_BAD_CLUS, 0, 0);
      return finish_with(f32rs_pkg::ST_FOUND, fc,
                         {entbuf[31], entbuf[30], entbuf[29], entbuf[28]});
    end
    bidx++;
    return entry_read();
  endfunction

  function automatic lookup_res_t fat_take(logic [7:0] b);
    logic [31:0] nxt;
    logic [63:0] lim;
    fword |= 32'(b) << (8 * bidx[1:0]);
    if (bidx < 3) begin
      bidx++;
      return mk_res(f32rs_pkg::KIND_READ, fat_off + 64'(cur_cl) * 64'd4 + 64'(bidx),
                    ST_NONE, 0, 0);
    end
    nxt = fword & 32'h0FFF_FFFF;
    if (nxt >= {4'h0, f32rs_pkg::FAT_EOC} || nxt == 0)
      return finish_with(f32rs_pkg::ST_CHAIN, 0, 0);
    lim = 64'(cfg_img) / 64'(csz != 0 ? csz : 32'd1) + 64'd2;
    if (64'(hops) + 64'd1 >= lim) return finish_with(f32rs_pkg::ST_CHAIN, 0, 0);
    hops++;
    cur_cl = nxt;
    return cluster_enter();
  endfunction

  function automatic bit lookup_step(input logic rt, input logic [7:0] b,
                                     output lookup_res_t r);
    r = '0;
    if (rt == f32rs_pkg::REQ_START) begin
      fat_off = 0; data_off = 0; csz = 0; cur_cl = 0; ent_idx = 0; bidx = 0;
      fword = 0; hops = 0;
      if (cfg_img < f32rs_pkg::BOOT_SECTOR_BYTES) begin
        r = finish_with(f32rs_pkg::ST_BAD_BOOT, 0, 0);
        return 1;
      end
      ph = LK_BOOT;
      r = mk_res(f32rs_pkg::KIND_READ, 64'd0, ST_NONE, 0, 0);
      return 1;
    end
    case (ph)
      LK_BOOT: begin
        boot_cap[bidx < 48 ? bidx : 8'd47] = b;
        if (bidx >= 8'(f32rs_pkg::BOOT_LAST)) r = boot_check();
        else begin
          bidx++;
          r = mk_res(f32rs_pkg::KIND_READ, 64'(bidx), ST_NONE, 0, 0);
        end
        return 1;
      end
      LK_DIR: begin
        r = dir_take(b);
        return 1;
      end
      LK_FAT: begin
        r = fat_take(b);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic logic [7:0] img_at(logic [31:0] a);
    return img_mem.exists(a) ? img_mem[a] : 8'h00;
  endfunction

  task automatic put_bytes(logic [63:0] a, logic [31:0] v, int n);
    for (int i = 0; i < n; i++) img_mem[32'(a + 64'(i))] = v[8*i +: 8];
  endtask

  task automatic push_item(input logic rt, input logic [7:0] b, input bit typed,
                           input lookup_res_t texp);
    lookup_res_t r;
    bit has;
    int gap;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= rt;
    in_ch.read_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    n_items++;
    has = lookup_step(rt, b, r);
    if (has) begin
      if (typed) r = texp;
      pending_res.push_back(r);
      if (r.kind == f32rs_pkg::KIND_READ) next_addr = r.addr;
    end
  endtask

  // hold off until every result is back and the block has settled
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_regs(logic [63:0] h, logic [23:0] t, logic [31:0] img);
    cfg_we <= 1'b1; cfg_index <= f32rs_pkg::CFG_NAME_HEAD; cfg_data <= h;
    @(posedge clk);
    cfg_index <= f32rs_pkg::CFG_NAME_TAIL; cfg_data <= 64'(t);
    @(posedge clk);
    cfg_index <= f32rs_pkg::CFG_IMAGE_SIZE; cfg_data <= 64'(img);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_head = h; cfg_tail = t; cfg_img = img;
  endtask

  function automatic logic [7:0] name_char();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'($urandom_range(0, 255));
    if (r == 1) return 8'h20;
    return 8'($urandom_range(65, 90));
  endfunction

  task automatic run_lookup();
    logic [63:0] h, fo, dof, need, a;
    logic [23:0] t;
    logic [31:0] img, bps, spc, rsv, nf, fs32, root, cs, epc, term, v;
    logic [31:0] cl [4];
    logic [7:0]  ent [32];
    int r, len, nfill, guard;
    lookup_res_t none;
    none = '0;
    r = $urandom_range(0, 19);
    for (int i = 0; i < 8; i++) h[8*i +: 8] = name_char();
    for (int i = 0; i < 3; i++) t[8*i +: 8] = name_char();
    if (r == 0) begin h = '1; t = '1; end
    else if (r == 1) begin h = '0; t = '0; end
    r = $urandom_range(0, 99);
    bps = r < 45 ? 512 : r < 60 ? 32 : r < 72 ? 64 : r < 80 ? 128 : r < 86 ? 16 :
          r < 90 ? 1 : r < 95 ? 4096 : r < 98 ? 256 : 32768;
    r = $urandom_range(0, 9);
    spc = r < 7 ? 1 : r == 7 ? 2 : r == 8 ? 4 : 128;
    rsv = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
    nf = ($urandom_range(0, 29) == 0) ? 255 : $urandom_range(1, 2);
    fs32 = $urandom_range(1, 4);
    root = $urandom_range(2, 6);
    cs = bps * spc;
    epc = cs / 32;
    len = $urandom_range(1, 4);
    cl[0] = root;
    for (int i = 1; i < len; i++) cl[i] = cl[i-1] + $urandom_range(1, 3);
    fo = 64'(rsv) * 64'(bps);
    dof = fo + 64'(nf) * 64'(fs32) * 64'(bps);
    need = dof + 64'(cl[len-1] - 1) * 64'(cs);
    if (fo + 64'(cl[len-1]) * 4 + 4 > need) need = fo + 64'(cl[len-1]) * 4 + 4;
    if (need < 512) need = 512;
    r = $urandom_range(0, 99);
    term = 0;
    case ($urandom_range(0, 5))
      0, 1: term = {4'($urandom), f32rs_pkg::FAT_EOC + 28'($urandom_range(0, 7))};
      2: term = {4'($urandom), 28'h0};
      3: term = 32'd1;
      4: begin term = root; r = 60; end
      default: term = ($urandom_range(0, 1) == 0) ? 32'h0FFF_FFF0 : $urandom;
    endcase
    if (r < 55) need = need + 64'($urandom_range(0, 4096));
    else if (r < 70) need = need;
    else if (r < 80) need = 64'hFFFF_FFFF;
    else if (r < 88) need = need - 64'($urandom_range(1, cs < 512 ? 512 : cs));
    else if (r < 94) need = 64'($urandom_range(0, 511));
    else need = 64'($urandom);
    img = (need > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : need[31:0];
    img_mem.delete();
    for (int i = 0; i < 48; i++) img_mem[i] = 8'($urandom);
    put_bytes(11, bps, 2);
    img_mem[13] = spc[7:0];
    put_bytes(14, rsv, 2);
    img_mem[16] = nf[7:0];
    put_bytes(17, 0, 2);
    put_bytes(22, 0, 2);
    put_bytes(36, fs32, 4);
    put_bytes(44, root, 4);
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 7))
        0: put_bytes(11, 32'd3 + $urandom_range(0, 2) * 2, 2);
        1: img_mem[13] = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd3;
        2: img_mem[16] = 8'd0;
        3: img_mem[18] = 8'($urandom_range(1, 255));
        4: img_mem[22] = 8'($urandom_range(1, 255));
        5: put_bytes(36, 0, 4);
        6: put_bytes(44, $urandom_range(0, 1), 4);
        default: put_bytes(14, 32'hFFFF, 2);
      endcase
    end
    for (int i = 0; i < len; i++) begin
      v = (i == len - 1) ? term : {4'($urandom), 28'(cl[i+1])};
      put_bytes(fo + 64'(cl[i]) * 4, v, 4);
      nfill = (epc <= 8) ? int'(epc) : $urandom_range(0, 6);
      for (int e = 0; e < nfill; e++) begin
        for (int k = 0; k < 32; k++) ent[k] = 8'($urandom);
        r = $urandom_range(0, 9);
        for (int k = 0; k < 11; k++)
          ent[k] = (r < 3 || r == 3) ? (k < 8 ? h[8*k +: 8] : t[8*(k-8) +: 8]) : name_char();
        if (r == 3) ent[$urandom_range(0, 10)] ^= 8'(1 << $urandom_range(0, 7));
        r = $urandom_range(0, 49);
        if (r < 4) ent[0] = f32rs_pkg::MARK_DEL;
        else if (r == 4) ent[0] = f32rs_pkg::MARK_END;
        r = $urandom_range(0, 19);
        ent[11] = r < 11 ? 8'h20 : r < 13 ? f32rs_pkg::ATTR_LFN : r < 15 ? 8'h08 :
                  r == 15 ? 8'h18 : ent[11];
        if ($urandom_range(0, 9) == 0) begin
          ent[20] = 0; ent[21] = 0; ent[27] = 0; ent[26] = 8'($urandom_range(0, 1));
        end
        a = dof + 64'(cl[i] - 2) * 64'(cs) + 64'(e) * 32;
        for (int k = 0; k < 32; k++) img_mem[32'(a + 64'(k))] = ent[k];
      end
    end
    drain();
    write_regs(h, t, img);
    push_item(f32rs_pkg::REQ_START, 8'($urandom), 0, none);
    guard = 0;
    // long chains are cut short; the next start drops the running lookup
    while (ph != LK_IDLE && guard < 400) begin
      guard++;
      r = $urandom_range(0, 199);
      if (r == 0) push_item(f32rs_pkg::REQ_START, 8'($urandom), 0, none);
      else if (r < 5) push_item(REQ_BYTE, 8'($urandom), 0, none);
      else push_item(REQ_BYTE, img_at(next_addr), 0, none);
    end
    // stray bytes with no lookup running
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) push_item(REQ_BYTE, 8'($urandom), 0, none);
  endtask

  seed_row_t seed_rows [13] = '{
    '{0, 0, f32rs_pkg::REQ_START, 8'h00, 1, 1, f32rs_pkg::KIND_DONE, 0, f32rs_pkg::ST_BAD_BOOT},
    '{0, 0, REQ_BYTE, 8'h5A, 3, 0, f32rs_pkg::KIND_READ, 0, ST_NONE},
    '{1, 511, f32rs_pkg::REQ_START, 8'h00, 1, 1, f32rs_pkg::KIND_DONE, 0,
      f32rs_pkg::ST_BAD_BOOT},
    '{1, 512, f32rs_pkg::REQ_START, 8'h00, 1, 1, f32rs_pkg::KIND_READ, 0, ST_NONE},
    '{0, 0, REQ_BYTE, 8'hFF, 47, 0, f32rs_pkg::KIND_READ, 0, ST_NONE},
    '{0, 0, REQ_BYTE, 8'hFF, 1, 1, f32rs_pkg::KIND_DONE, 0, f32rs_pkg::ST_BAD_BOOT},
    '{0, 0, f32rs_pkg::REQ_START, 8'h00, 1, 1, f32rs_pkg::KIND_READ, 0, ST_NONE},
    '{0, 0, REQ_BYTE, 8'h00, 5, 0, f32rs_pkg::KIND_READ, 0, ST_NONE},
    '{0, 0, f32rs_pkg::REQ_START, 8'h00, 1, 1, f32rs_pkg::KIND_READ, 0, ST_NONE},
    '{0, 0, REQ_BYTE, 8'h00, 47, 0, f32rs_pkg::KIND_READ, 0, ST_NONE},
    '{0, 0, REQ_BYTE, 8'h00, 1, 1, f32rs_pkg::KIND_DONE, 0, f32rs_pkg::ST_BAD_BOOT},
    '{1, 32'hFFFF_FFFF, f32rs_pkg::REQ_START, 8'h00, 1, 1, f32rs_pkg::KIND_READ, 0, ST_NONE},
    '{0, 0, REQ_BYTE, 8'h80, 48, 0, f32rs_pkg::KIND_READ, 0, ST_NONE}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic check_field(string fname, logic [31:0] e, logic [31:0] act);
    if (e !== act) begin
      errors++;
      $display("%0t %s: expected %h actual %h", $realtime, fname, e, act);
    end
  endtask

  always @(posedge clk) begin
    lookup_res_t e;
    if (rdy_left == 0) begin
      rdy_left = $urandom_range(1, 40);
      out_ch.ready <= ($urandom_range(0, 9) < 3) ? 1'b0 : 1'b1;
      if (out_ch.ready == 1'b0) rdy_left = rdy_left > 12 ? 12 : rdy_left;
    end else rdy_left--;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_res.size() == 0) begin
        errors++;
        $display("%0t unexpected result kind %h addr %h", $realtime, out_ch.out_kind,
                 out_ch.read_address);
      end else begin
        e = pending_res.pop_front();
        check_field("out_kind", 32'(e.kind), 32'(out_ch.out_kind));
        check_field("read_address", e.addr, out_ch.read_address);
        check_field("status", 32'(e.status), 32'(out_ch.status));
        check_field("first_cluster", e.fc, out_ch.first_cluster);
        check_field("file_size", e.fsz, out_ch.file_size);
        check_field("data_offset", e.doff, out_ch.data_offset);
        check_field("cluster_bytes", 32'(e.cb), 32'(out_ch.cluster_bytes));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) wd <= 0;
    else begin
      wd <= wd + 1;
      if (wd >= WD_LIMIT) begin
        $display("fat32_root_short_name_finder: mismatch");
        $finish;
      end
    end
  end

  initial begin
    lookup_res_t texp;
    rst <= 1'b1;
    cfg_we <= 1'b0; cfg_index <= f32rs_pkg::CFG_NAME_HEAD; cfg_data <= '0;
    in_ch.valid <= 1'b0; in_ch.req_type <= f32rs_pkg::REQ_START; in_ch.read_byte <= '0;
    cfg_head = 0; cfg_tail = 0; cfg_img = 0;
    ph = LK_IDLE;
    fat_off = 0; data_off = 0; csz = 0; cur_cl = 0; ent_idx = 0; bidx = 0;
    fword = 0; hops = 0; next_addr = 0;
    foreach (boot_cap[i]) boot_cap[i] = 0;
    foreach (entbuf[i]) entbuf[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (seed_rows[i]) begin
      if (seed_rows[i].set_img) begin
        drain();
        write_regs(cfg_head, cfg_tail, seed_rows[i].img);
      end
      texp = '0;
      texp.kind = seed_rows[i].kind;
      texp.addr = seed_rows[i].addr;
      texp.status = seed_rows[i].st;
      repeat (seed_rows[i].reps)
        push_item(seed_rows[i].rt, seed_rows[i].b, seed_rows[i].typed, texp);
    end
    while (n_items < ITEM_GOAL) run_lookup();
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("fat32_root_short_name_finder: match");
    else $display("fat32_root_short_name_finder: mismatch");
    $finish;
  end

endmodule

// File: sim.f
rtl/f32rs_pkg.sv
rtl/f32rs_if.sv
rtl/f32rs_ram.sv
rtl/fat32_root_short_name_finder.sv
test/fat32_root_short_name_finder_tb.sv
